// File: src/decimal_add_sub_clamped_macros.svh
`ifndef DECIMAL_ADD_SUB_CLAMPED_MACROS_SVH
`define DECIMAL_ADD_SUB_CLAMPED_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DASC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DASC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/dasc_pkg.sv
`default_nettype none

package dasc_pkg;

   localparam int MAX_DIGITS_DEFAULT = 32;
   localparam int DIGIT_W            = 4;

   localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
   localparam logic [DIGIT_W:0]   RADIX      = 5'd10;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETUP,
      ST_READ,
      ST_EMIT
   } dasc_state_type;

   typedef enum logic [1:0] {
      SRC_MEM,
      SRC_ONE,
      SRC_ZERO
   } dasc_src_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic read;
      logic advance;
      logic clear;
   } dasc_cmd_type;

   typedef struct packed {
      logic last_digit;
   } dasc_status_type;

   function automatic logic [DIGIT_W-1:0] clamp_digit(input logic [DIGIT_W-1:0] d);
      clamp_digit = (d > DIGIT_NINE) ? DIGIT_NINE : d;
   endfunction

endpackage

`default_nettype wire

// File: src/dasc_ctrl.sv
`default_nettype none

module dasc_ctrl
   import dasc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_last_pair,
   input  wire logic            rsp_stall,
   input  wire dasc_status_type status,
   output dasc_cmd_type         cmd,
   output logic                 req_stall,
   output logic                 rsp_valid
);

   dasc_state_type state_ff;
   dasc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last_pair) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = status.last_digit ? ST_LOAD : ST_READ;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.clear   = status.last_digit;
               cmd.advance = !status.last_digit;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/dasc_datapath.sv
`default_nettype none

module dasc_datapath
   import dasc_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dasc_cmd_type       cmd,
   input  wire logic [DIGIT_W-1:0] req_digit_a,
   input  wire logic [DIGIT_W-1:0] req_digit_b,
   input  wire logic               req_subtract,
   output dasc_status_type         status,
   output logic [DIGIT_W-1:0]      rsp_result_digit,
   output logic                    rsp_overflow
);

   localparam int IW = $clog2(MAX_DIGITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_DIGITS);

   logic [DIGIT_W-1:0] mem [MAX_DIGITS];

   logic [CW-1:0]      count_ff, count_in;
   logic               carry_ff, carry_in;
   logic               op_ff, op_in;
   logic               ovf_ff, ovf_in;
   logic [IW-1:0]      topnz_ff, topnz_in;
   logic [IW-1:0]      ptr_ff, ptr_in;
   dasc_src_type       src_ff, src_in;
   logic [DIGIT_W-1:0] rd_ff;

   logic [DIGIT_W-1:0] a, b, d;
   logic [DIGIT_W:0]   sum, sub;
   logic               carry_next;
   logic               op_now;
   logic               full;

   assign a      = clamp_digit(req_digit_a);
   assign b      = clamp_digit(req_digit_b);
   assign full   = (count_ff == COUNT_FULL);
   assign op_now = (count_ff == '0) ? req_subtract : op_ff;
   assign sum    = {1'b0, a} + {1'b0, b} + {{DIGIT_W{1'b0}}, carry_ff};
   assign sub    = {1'b0, b} + {{DIGIT_W{1'b0}}, carry_ff};

   // One decimal digit step; a borrow wraps the difference round by ten.
   always_comb begin
      if (op_now) begin
         if ({1'b0, a} >= sub) begin
            d          = DIGIT_W'({1'b0, a} - sub);
            carry_next = 1'b0;
         end else begin
            d          = DIGIT_W'({1'b0, a} + RADIX - sub);
            carry_next = 1'b1;
         end
      end else begin
         if (sum >= RADIX) begin
            d          = DIGIT_W'(sum - RADIX);
            carry_next = 1'b1;
         end else begin
            d          = DIGIT_W'(sum);
            carry_next = 1'b0;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      carry_in = carry_ff;
      op_in    = op_ff;
      ovf_in   = ovf_ff;
      topnz_in = topnz_ff;
      ptr_in   = ptr_ff;
      src_in   = src_ff;
      if (cmd.clear) begin
         count_in = '0;
         carry_in = 1'b0;
         op_in    = 1'b0;
         ovf_in   = 1'b0;
         topnz_in = '0;
      end else if (cmd.load) begin
         op_in = op_now;
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            carry_in = carry_next;
            count_in = count_ff + CW'(1);
            if (d != '0) begin
               topnz_in = count_ff[IW-1:0];
            end
         end
      end else if (cmd.setup) begin
         // A final borrow clamps to zero; a final carry leads with a one.
         priority if (op_ff && carry_ff) begin
            src_in = SRC_ZERO;
            ptr_in = '0;
         end else if (carry_ff) begin
            src_in = SRC_ONE;
            ptr_in = IW'(count_ff - CW'(1));
         end else begin
            src_in = SRC_MEM;
            ptr_in = topnz_ff;
         end
      end else if (cmd.advance) begin
         if (src_ff == SRC_MEM) begin
            ptr_in = ptr_ff - IW'(1);
         end else begin
            src_in = SRC_MEM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         carry_ff <= 1'b0;
         op_ff    <= 1'b0;
         ovf_ff   <= 1'b0;
         topnz_ff <= '0;
         src_ff   <= SRC_MEM;
      end else begin
         count_ff <= count_in;
         carry_ff <= carry_in;
         op_ff    <= op_in;
         ovf_ff   <= ovf_in;
         topnz_ff <= topnz_in;
         src_ff   <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[count_ff[IW-1:0]] <= d;
      end
      if (cmd.read) begin
         rd_ff <= mem[ptr_ff];
      end
   end

   always_comb begin
      unique case (src_ff)
         SRC_ONE:  rsp_result_digit = DIGIT_W'(1);
         SRC_ZERO: rsp_result_digit = '0;
         default:  rsp_result_digit = rd_ff;
      endcase
   end

   assign rsp_overflow      = ovf_ff;
   assign status.last_digit = (src_ff == SRC_ZERO) || ((src_ff == SRC_MEM) && (ptr_ff == '0));

endmodule

`default_nettype wire

// File: src/decimal_add_sub_clamped.sv
`default_nettype none

// Streaming decimal adder and subtractor. Each item is one aligned digit pair,
// least significant first; the subtract flag of the first pair sets the
// operation and last_pair ends it. Pairs are taken back to back while the
// block loads. After the last pair the block passes a setup state and then,
// for each result digit, a read state and an emit state that holds while the
// output stalls, limited by the single registered read port of the digit store.
// Results come most significant first without leading zeros; a subtraction
// whose minuend is not greater than the subtrahend gives a single zero.
// Pairs beyond MAX_DIGITS are dropped and flag overflow on every result item.

`include "decimal_add_sub_clamped_macros.svh"

module decimal_add_sub_clamped
   import dasc_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [DIGIT_W-1:0] req_digit_a,
   input  wire logic [DIGIT_W-1:0] req_digit_b,
   input  wire logic               req_subtract,
   input  wire logic               req_last_pair,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [DIGIT_W-1:0]      rsp_result_digit,
   output logic                    rsp_last_digit,
   output logic                    rsp_overflow
);

   dasc_cmd_type    cmd;
   dasc_status_type status;

   dasc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_pair (req_last_pair),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid)
   );

   dasc_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_digit_a      (req_digit_a),
      .req_digit_b      (req_digit_b),
      .req_subtract     (req_subtract),
      .status           (status),
      .rsp_result_digit (rsp_result_digit),
      .rsp_overflow     (rsp_overflow)
   );

   assign rsp_last_digit = status.last_digit;

   `DASC_ASSERT_NOW(a_no_req_while_rsp, clock, reset, rsp_valid, req_stall, "item accepted while results pending")
   `DASC_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && !req_stall && req_last_pair, req_stall && !rsp_valid, "block not busy after last pair")
   `DASC_ASSERT_NEXT(a_free_after_final, clock, reset, rsp_valid && !rsp_stall && rsp_last_digit, !req_stall && !rsp_valid, "block not free after final digit")

endmodule

`default_nettype wire

// File: sim/decimal_add_sub_clamped_tb.sv
module decimal_add_sub_clamped_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dasc_pkg::*;

   localparam int DIGITS = MAX_DIGITS_DEFAULT;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
      logic               ovf;
   } sum_digit_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] a;
      logic [DIGIT_W-1:0] b;
      logic               sub;
      logic               last;
      logic               typed;
      logic [DIGIT_W-1:0] want;
   } pair_row_type;

   // Rows flagged as typed end an operation whose single result digit is obvious.
   localparam pair_row_type DIRECTED_ROWS [20] = '{
      '{4'd0,  4'd0,  1'b0, 1'b1, 1'b1, 4'd0},
      '{4'd9,  4'd9,  1'b0, 1'b1, 1'b0, 4'd0},
      '{4'd0,  4'd15, 1'b0, 1'b1, 1'b1, 4'd9},
      '{4'd15, 4'd0,  1'b1, 1'b1, 1'b1, 4'd9},
      '{4'd12, 4'd10, 1'b1, 1'b1, 1'b1, 4'd0},
      '{4'd3,  4'd5,  1'b1, 1'b1, 1'b1, 4'd0},
      '{4'd9,  4'd1,  1'b0, 1'b0, 1'b0, 4'd0},
      '{4'd9,  4'd0,  1'b1, 1'b0, 1'b0, 4'd0},
      '{4'd9,  4'd0,  1'b0, 1'b1, 1'b0, 4'd0},
      '{4'd5,  4'd0,  1'b1, 1'b0, 1'b0, 4'd0},
      '{4'd0,  4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
      '{4'd0,  4'd0,  1'b1, 1'b0, 1'b0, 4'd0},
      '{4'd1,  4'd1,  1'b0, 1'b1, 1'b1, 4'd5},
      '{4'd2,  4'd2,  1'b1, 1'b0, 1'b0, 4'd0},
      '{4'd4,  4'd4,  1'b1, 1'b1, 1'b1, 4'd0},
      '{4'd0,  4'd1,  1'b1, 1'b0, 1'b0, 4'd0},
      '{4'd0,  4'd0,  1'b1, 1'b0, 1'b0, 4'd0},
      '{4'd1,  4'd0,  1'b0, 1'b1, 1'b0, 4'd0},
      '{4'd15, 4'd15, 1'b0, 1'b0, 1'b0, 4'd0},
      '{4'd14, 4'd13, 1'b1, 1'b1, 1'b0, 4'd0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [DIGIT_W-1:0] req_digit_a = '0;
   logic [DIGIT_W-1:0] req_digit_b = '0;
   logic               req_subtract = 1'b0;
   logic               req_last_pair = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [DIGIT_W-1:0] rsp_result_digit;
   logic               rsp_last_digit;
   logic               rsp_overflow;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;

   // Predictor state.
   logic [DIGIT_W-1:0] partial_digits [0:DIGITS];
   logic               carry_in;
   int                 pairs_taken;
   logic               op_is_sub;
   logic               ovf_seen;

   sum_digit_type fresh_digits [$];
   sum_digit_type awaited_digits [$];
   sum_digit_type head;

   decimal_add_sub_clamped #(
      .MAX_DIGITS(DIGITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_digit_a     (req_digit_a),
      .req_digit_b     (req_digit_b),
      .req_subtract    (req_subtract),
      .req_last_pair   (req_last_pair),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_digit(rsp_result_digit),
      .rsp_last_digit  (rsp_last_digit),
      .rsp_overflow    (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Adds or subtracts one digit pair; on the last pair the result digits are
   // queued most significant first.
   function automatic void accumulate_pair(logic [DIGIT_W-1:0] a_in, logic [DIGIT_W-1:0] b_in,
                                           logic sub_in, logic last_in);
      int a;
      int b;
      int d;
      int n;
      int top;
      a = (a_in > 4'd9) ? 9 : int'(a_in);
      b = (b_in > 4'd9) ? 9 : int'(b_in);
      if (pairs_taken == 0) op_is_sub = sub_in;
      if (pairs_taken < DIGITS) begin
         if (op_is_sub) begin
            d = a - b - int'(carry_in);
            carry_in = (d < 0);
            if (d < 0) d = d + 10;
         end else begin
            d = a + b + int'(carry_in);
            carry_in = (d >= 10);
            if (d >= 10) d = d - 10;
         end
         partial_digits[pairs_taken] = d[DIGIT_W-1:0];
         pairs_taken++;
      end else begin
         ovf_seen = 1'b1;
      end
      if (!last_in) return;
      n = pairs_taken;
      if (!op_is_sub && carry_in) begin
         partial_digits[n] = 4'd1;
         n++;
      end
      if (op_is_sub && carry_in) begin
         fresh_digits.push_back('{4'd0, 1'b1, ovf_seen});
      end else begin
         top = n - 1;
         while (top > 0 && partial_digits[top] == 4'd0) top--;
         for (int i = top; i >= 0; i--) begin
            fresh_digits.push_back('{partial_digits[i], i == 0, ovf_seen});
         end
      end
      carry_in = 1'b0;
      pairs_taken = 0;
      op_is_sub = 1'b0;
      ovf_seen = 1'b0;
   endfunction

   task automatic send_pair(input logic [DIGIT_W-1:0] a, input logic [DIGIT_W-1:0] b,
                            input logic sub, input logic last,
                            input logic typed, input logic [DIGIT_W-1:0] want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_digit_a <= a;
      req_digit_b <= b;
      req_subtract <= sub;
      req_last_pair <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_pair(a, b, sub, last);
      if (typed) begin
         fresh_digits.delete();
         awaited_digits.push_back('{want, 1'b1, 1'b0});
      end else begin
         while (fresh_digits.size() != 0) awaited_digits.push_back(fresh_digits.pop_front());
      end
   endtask

   // Holds the sender off until every awaited digit has come out.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_digits.size() != 0);
   endtask

   // Mostly short operations, some long ones and a few that overrun the store.
   task automatic random_operation(inout int sent);
      int len;
      int roll;
      logic sub;
      logic [DIGIT_W-1:0] a;
      logic [DIGIT_W-1:0] b;
      roll = $urandom_range(99);
      if (roll < 70) len = $urandom_range(6, 1);
      else if (roll < 95) len = $urandom_range(DIGITS, 7);
      else len = $urandom_range(DIGITS + 4, DIGITS + 1);
      sub = 1'($urandom_range(1));
      for (int i = 0; i < len; i++) begin
         a = DIGIT_W'(($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(9));
         b = DIGIT_W'(($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(9));
         if ($urandom_range(3) == 0) b = a;
         send_pair(a, b, (i == 0) ? sub : logic'($urandom_range(1)), i == len - 1, 1'b0, 4'd0);
         sent++;
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_digits.size() == 0) begin
            $display("%0t: unexpected item, expected none, got digit %0d last %0b overflow %0b",
                     $time, rsp_result_digit, rsp_last_digit, rsp_overflow);
            mismatches++;
         end else begin
            head = awaited_digits.pop_front();
            if (rsp_result_digit !== head.digit) begin
               $display("%0t: result_digit expected %0d got %0d",
                        $time, head.digit, rsp_result_digit);
               mismatches++;
            end
            if (rsp_last_digit !== head.last) begin
               $display("%0t: last_digit expected %0b got %0b", $time, head.last, rsp_last_digit);
               mismatches++;
            end
            if (rsp_overflow !== head.ovf) begin
               $display("%0t: overflow expected %0b got %0b", $time, head.ovf, rsp_overflow);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int sent;
      carry_in = 1'b0;
      pairs_taken = 0;
      op_is_sub = 1'b0;
      ovf_seen = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 32;
      recv_stall_pct = 45;
      foreach (DIRECTED_ROWS[i]) begin
         send_pair(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].sub,
                   DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end
      // Every pair carries and the run overruns the store, so the result is as long as it can be.
      for (int i = 0; i < DIGITS + 3; i++) begin
         send_pair(4'd9, 4'd9, 1'b0, i == DIGITS + 2, 1'b0, 4'd0);
      end
      wait_for_drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 45 : 0;
         recv_stall_pct = (phase == 0) ? 45 : (phase == 1) ? 32 : 0;
         sent = 0;
         while (sent < 45) random_operation(sent);
         wait_for_drain();
      end

      recv_stall_pct = 0;
      repeat (40) @(posedge clock);
      if (mismatches == 0 && awaited_digits.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
